FILE: src/cau_pkg.sv
// cau_pkg: shared types, operation codes and saturation helpers for the
// complex arithmetic unit; no dependencies
package cau_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    localparam int PART_W = 16;
    localparam int QUOT_W = 16;
    localparam int WIDE_W = 33;

    // per-item information carried alongside the divider
    typedef struct packed {
        logic              is_div;
        logic              dz;
        logic              big_re;
        logic              big_im;
        logic              neg_re;
        logic              neg_im;
        logic              ovf;
        logic [PART_W-1:0] re;
        logic [PART_W-1:0] im;
    } side_t;

    // returns {overflow, value}
    function automatic logic [PART_W:0] sat_wide(input logic signed [WIDE_W-1:0] x);
        logic [PART_W:0] r;
        if (x > $signed(WIDE_W'(32767)))
            r = {1'b1, 16'h7fff};
        else if (x < -$signed(WIDE_W'(32768)))
            r = {1'b1, 16'h8000};
        else
            r = {1'b0, x[PART_W-1:0]};
        return r;
    endfunction

    // signs and saturates a quotient magnitude, returns {overflow, value}
    function automatic logic [PART_W:0] div_part(input logic big, input logic neg,
                                                 input logic [QUOT_W-1:0] q);
        logic [PART_W:0] r;
        if (big)
            r = {1'b1, (neg ? 16'h8000 : 16'h7fff)};
        else if (neg)
            r = (q > 16'd32768) ? {1'b1, 16'h8000} : {1'b0, (~q) + 16'd1};
        else
            r = (q > 16'd32767) ? {1'b1, 16'h7fff} : {1'b0, q};
        return r;
    endfunction

endpackage

FILE: src/cau_req_if.sv
// cau_req_if: request channel of the complex arithmetic unit
// depends on nothing
interface cau_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;

    modport source (output valid, action, a_re, a_im, b_re, b_im, input ready);
    modport sink (input valid, action, a_re, a_im, b_re, b_im, output ready);
endinterface

FILE: src/cau_rsp_if.sv
// cau_rsp_if: result channel of the complex arithmetic unit
// depends on nothing
interface cau_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] res_re;
    logic signed [15:0] res_im;
    logic               overflow;
    logic               div_zero;

    modport source (output valid, res_re, res_im, overflow, div_zero, input ready);
    modport sink (input valid, res_re, res_im, overflow, div_zero, output ready);
endinterface

FILE: src/cau_front.sv
// cau_front: three pipeline stages: products, sums, divide preparation
// depends on cau_pkg
module cau_front
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    parameter int W         = 49
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [2:0]         en,
    input  logic [1:0]         action,
    input  logic signed [15:0] a_re,
    input  logic signed [15:0] a_im,
    input  logic signed [15:0] b_re,
    input  logic signed [15:0] b_im,
    output logic [2:0]         v,
    output logic [W-1:0]       rem_re,
    output logic [W-1:0]       rem_im,
    output logic [W-1:0]       den,
    output side_t              side
);
    localparam int NW = WIDE_W + FRAC_BITS;

    logic [2:0] v_reg;

    // stage 1
    op_t                s1_op_reg;
    logic signed [31:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg, q_r_reg, q_i_reg;
    logic signed [16:0] as_re_reg, as_im_reg;
    logic               s1_dz_reg;

    // stage 2
    op_t                       s2_op_reg;
    logic signed [WIDE_W-1:0]  re_w_reg, im_w_reg;
    logic [31:0]               den_w_reg;
    logic                      s2_dz_reg;

    // stage 3
    logic [W-1:0] rem_re_reg, rem_im_reg, den_reg;
    side_t        side_reg;

    logic signed [16:0] as_re_next, as_im_next;
    logic signed [NW-1:0] num_re, num_im;
    logic signed [W-1:0]  ext_re, ext_im;
    logic [W-1:0]         mag_re, mag_im, den_ext, lim;
    logic signed [WIDE_W-1:0] sh_re, sh_im;
    logic [PART_W:0]      sat_re, sat_im;
    side_t                side_next;

    always_comb
    begin
        if (op_t'(action) == OP_SUB)
        begin
            as_re_next = 17'(a_re) - 17'(b_re);
            as_im_next = 17'(a_im) - 17'(b_im);
        end
        else
        begin
            as_re_next = 17'(a_re) + 17'(b_re);
            as_im_next = 17'(a_im) + 17'(b_im);
        end
    end

    always_comb
    begin
        num_re  = NW'(re_w_reg) <<< FRAC_BITS;
        num_im  = NW'(im_w_reg) <<< FRAC_BITS;
        ext_re  = W'(num_re);
        ext_im  = W'(num_im);
        mag_re  = ext_re[W-1] ? W'(-ext_re) : W'(ext_re);
        mag_im  = ext_im[W-1] ? W'(-ext_im) : W'(ext_im);
        den_ext = W'(den_w_reg);
        lim     = den_ext << QUOT_W;
        sh_re   = (s2_op_reg == OP_MUL) ? (re_w_reg >>> FRAC_BITS) : re_w_reg;
        sh_im   = (s2_op_reg == OP_MUL) ? (im_w_reg >>> FRAC_BITS) : im_w_reg;
        sat_re  = sat_wide(sh_re);
        sat_im  = sat_wide(sh_im);

        side_next.is_div = (s2_op_reg == OP_DIV);
        side_next.dz     = (s2_op_reg == OP_DIV) && s2_dz_reg;
        side_next.big_re = (mag_re >= lim);
        side_next.big_im = (mag_im >= lim);
        side_next.neg_re = ext_re[W-1];
        side_next.neg_im = ext_im[W-1];
        side_next.ovf    = sat_re[PART_W] | sat_im[PART_W];
        side_next.re     = sat_re[PART_W-1:0];
        side_next.im     = sat_im[PART_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_op_reg <= op_t'(action);
            p_rr_reg  <= a_re * b_re;
            p_ii_reg  <= a_im * b_im;
            p_ir_reg  <= a_im * b_re;
            p_ri_reg  <= a_re * b_im;
            q_r_reg   <= b_re * b_re;
            q_i_reg   <= b_im * b_im;
            as_re_reg <= as_re_next;
            as_im_reg <= as_im_next;
            s1_dz_reg <= (b_re == 16'sd0) && (b_im == 16'sd0);
        end
        if (en[1])
        begin
            s2_op_reg <= s1_op_reg;
            s2_dz_reg <= s1_dz_reg;
            den_w_reg <= $unsigned(q_r_reg) + $unsigned(q_i_reg);
            unique case (s1_op_reg)
                OP_MUL:
                begin
                    re_w_reg <= WIDE_W'(p_rr_reg) - WIDE_W'(p_ii_reg);
                    im_w_reg <= WIDE_W'(p_ir_reg) + WIDE_W'(p_ri_reg);
                end
                OP_DIV:
                begin
                    re_w_reg <= WIDE_W'(p_rr_reg) + WIDE_W'(p_ii_reg);
                    im_w_reg <= WIDE_W'(p_ir_reg) - WIDE_W'(p_ri_reg);
                end
                default:
                begin
                    re_w_reg <= WIDE_W'(as_re_reg);
                    im_w_reg <= WIDE_W'(as_im_reg);
                end
            endcase
        end
        if (en[2])
        begin
            rem_re_reg <= side_next.big_re ? '0 : mag_re;
            rem_im_reg <= side_next.big_im ? '0 : mag_im;
            den_reg    <= den_ext;
            side_reg   <= side_next;
        end
    end

    assign v      = v_reg;
    assign rem_re = rem_re_reg;
    assign rem_im = rem_im_reg;
    assign den    = den_reg;
    assign side   = side_reg;
endmodule

FILE: src/cau_div_step.sv
// cau_div_step: one registered restoring-division step for both parts
// depends on cau_pkg
module cau_div_step
    import cau_pkg::*;
#(
    parameter int W = 49,
    parameter int K = 15
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [W-1:0]      in_rem_re,
    input  logic [W-1:0]      in_rem_im,
    input  logic [W-1:0]      in_den,
    input  logic [QUOT_W-1:0] in_q_re,
    input  logic [QUOT_W-1:0] in_q_im,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [W-1:0]      out_rem_re,
    output logic [W-1:0]      out_rem_im,
    output logic [W-1:0]      out_den,
    output logic [QUOT_W-1:0] out_q_re,
    output logic [QUOT_W-1:0] out_q_im,
    output side_t             out_side
);
    logic              valid_reg;
    logic [W-1:0]      rem_re_reg, rem_im_reg, den_reg;
    logic [QUOT_W-1:0] q_re_reg, q_im_reg;
    side_t             side_reg;

    logic [W-1:0]      sh;
    logic              ge_re, ge_im;
    logic [QUOT_W-1:0] q_re_next, q_im_next;

    always_comb
    begin
        sh        = in_den << K;
        ge_re     = (in_rem_re >= sh);
        ge_im     = (in_rem_im >= sh);
        q_re_next = in_q_re;
        q_im_next = in_q_im;
        q_re_next[K] = ge_re;
        q_im_next[K] = ge_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_re_reg <= ge_re ? in_rem_re - sh : in_rem_re;
            rem_im_reg <= ge_im ? in_rem_im - sh : in_rem_im;
            den_reg    <= in_den;
            q_re_reg   <= q_re_next;
            q_im_reg   <= q_im_next;
            side_reg   <= in_side;
        end
    end

    assign out_valid  = valid_reg;
    assign out_rem_re = rem_re_reg;
    assign out_rem_im = rem_im_reg;
    assign out_den    = den_reg;
    assign out_q_re   = q_re_reg;
    assign out_q_im   = q_im_reg;
    assign out_side   = side_reg;
endmodule

FILE: src/complex_arith_unit.sv
// complex_arith_unit: pipelined complex add, subtract, multiply and divide
// stages: products, sums, divide prep, 16 quotient-bit steps, output
// throughput one request per cycle while rsp.ready is high; a full stage holds when its successor cannot load
// reset clears all stage valid bits at once; no other state
// depends on cau_pkg, cau_req_if, cau_rsp_if, cau_front, cau_div_step
module complex_arith_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 8
)(
    input  logic  clk,
    input  logic  rst_n,
    cau_req_if.sink   req,
    cau_rsp_if.source rsp
);
    localparam int NW = WIDE_W + FRAC_BITS;
    localparam int W  = ((NW > 48) ? NW : 48) + 1;
    localparam int NS = 3 + QUOT_W + 1;

    logic [NS-1:0] v;
    logic [NS-1:0] en;

    logic [W-1:0]      rem_re [QUOT_W+1];
    logic [W-1:0]      rem_im [QUOT_W+1];
    logic [W-1:0]      den    [QUOT_W+1];
    logic [QUOT_W-1:0] q_re   [QUOT_W+1];
    logic [QUOT_W-1:0] q_im   [QUOT_W+1];
    side_t             side   [QUOT_W+1];

    logic               out_valid_reg;
    logic signed [15:0] res_re_reg, res_im_reg;
    logic               ovf_reg, dz_reg;

    logic [PART_W:0] dp_re, dp_im;
    side_t           fs;

    // each stage may load when it is empty or its successor loads
    always_comb
    begin
        en[NS-1] = !v[NS-1] || rsp.ready;
        for (int i = NS - 2; i >= 0; i--)
            en[i] = !v[i] || en[i+1];
    end

    assign req.ready = en[0];

    cau_front #(.FRAC_BITS(FRAC_BITS), .W(W)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .en       (en[2:0]),
        .action   (req.action),
        .a_re     (req.a_re),
        .a_im     (req.a_im),
        .b_re     (req.b_re),
        .b_im     (req.b_im),
        .v        (v[2:0]),
        .rem_re   (rem_re[0]),
        .rem_im   (rem_im[0]),
        .den      (den[0]),
        .side     (side[0])
    );

    assign q_re[0] = '0;
    assign q_im[0] = '0;

    for (genvar g = 0; g < QUOT_W; g++)
    begin : g_step
        cau_div_step #(.W(W), .K(QUOT_W - 1 - g)) u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en[3+g]),
            .in_valid   (v[2+g]),
            .in_rem_re  (rem_re[g]),
            .in_rem_im  (rem_im[g]),
            .in_den     (den[g]),
            .in_q_re    (q_re[g]),
            .in_q_im    (q_im[g]),
            .in_side    (side[g]),
            .out_valid  (v[3+g]),
            .out_rem_re (rem_re[g+1]),
            .out_rem_im (rem_im[g+1]),
            .out_den    (den[g+1]),
            .out_q_re   (q_re[g+1]),
            .out_q_im   (q_im[g+1]),
            .out_side   (side[g+1])
        );
    end

    // output stage: sign and saturate quotients, pick the result
    always_comb
    begin
        fs    = side[QUOT_W];
        dp_re = div_part(fs.big_re, fs.neg_re, q_re[QUOT_W]);
        dp_im = div_part(fs.big_im, fs.neg_im, q_im[QUOT_W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en[NS-1])
            out_valid_reg <= v[NS-2];
    end

    assign v[NS-1] = out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            priority if (!fs.is_div)
            begin
                res_re_reg <= fs.re;
                res_im_reg <= fs.im;
                ovf_reg    <= fs.ovf;
                dz_reg     <= 1'b0;
            end
            else if (fs.dz)
            begin
                res_re_reg <= '0;
                res_im_reg <= '0;
                ovf_reg    <= 1'b0;
                dz_reg     <= 1'b1;
            end
            else
            begin
                res_re_reg <= dp_re[PART_W-1:0];
                res_im_reg <= dp_im[PART_W-1:0];
                ovf_reg    <= dp_re[PART_W] | dp_im[PART_W];
                dz_reg     <= 1'b0;
            end
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.res_re   = res_re_reg;
    assign rsp.res_im   = res_im_reg;
    assign rsp.overflow = ovf_reg;
    assign rsp.div_zero = dz_reg;
endmodule
